### hdl/assert_macros.svh
// Assertion macros included by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a condition at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// Check that one condition implies another in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### hdl/qrm_pkg.sv
// Shared types and constants of the quaternion to rotation matrix block
package qrm_pkg;
    localparam int NumEntries = 9;
    localparam int NumProducts = 10;

    typedef struct packed {
        logic valid;
        logic zero;
    } qrm_ctl_t;
endpackage

### hdl/qrm_in_if.sv
// Input channel: one quaternion per item
interface qrm_in_if #(
    parameter int W = 16
);
    logic valid;
    logic ready;
    logic signed [W-1:0] q_scalar;
    logic signed [W-1:0] q_i;
    logic signed [W-1:0] q_j;
    logic signed [W-1:0] q_k;

    modport source (output valid, q_scalar, q_i, q_j, q_k, input ready);
    modport sink (input valid, q_scalar, q_i, q_j, q_k, output ready);
endinterface

### hdl/qrm_out_if.sv
// Output channel: one rotation matrix per item
interface qrm_out_if #(
    parameter int W = 16
);
    logic valid;
    logic ready;
    logic signed [W-1:0] m00;
    logic signed [W-1:0] m01;
    logic signed [W-1:0] m02;
    logic signed [W-1:0] m10;
    logic signed [W-1:0] m11;
    logic signed [W-1:0] m12;
    logic signed [W-1:0] m20;
    logic signed [W-1:0] m21;
    logic signed [W-1:0] m22;
    logic zero_norm;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    zero_norm, input ready);
    modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  zero_norm, output ready);
endinterface

### hdl/qrm_front.sv
// Front stages: input capture, pair products, numerators, magnitudes
module qrm_front #(
    parameter int C  = 16,
    parameter int NW = 34
) (
    input  logic clk,
    input  logic rst_n,
    input  logic [3:0] en,
    input  logic in_valid,
    input  logic signed [C-1:0] w,
    input  logic signed [C-1:0] x,
    input  logic signed [C-1:0] y,
    input  logic signed [C-1:0] z,
    output logic [2:0] inner_valid,
    output qrm_pkg::qrm_ctl_t ctl,
    output logic [NW-1:0] n,
    output logic [qrm_pkg::NumEntries-1:0][NW-1:0] mag,
    output logic [qrm_pkg::NumEntries-1:0] neg
);
    import qrm_pkg::*;

    localparam int P = 2 * C;

    logic v0_reg, v1_reg, v2_reg;
    logic signed [C-1:0] w_reg, x_reg, y_reg, z_reg;
    logic signed [NumProducts-1:0][P-1:0] prod_reg;
    logic signed [NumProducts-1:0][P-1:0] prod_next;
    logic signed [NumEntries-1:0][NW-1:0] num_reg;
    logic signed [NumEntries-1:0][NW-1:0] num_next;
    logic [NW-1:0] n1_reg, n1_next;
    qrm_ctl_t ctl_reg;
    logic [NW-1:0] n_reg;
    logic [NumEntries-1:0][NW-1:0] mag_reg, mag_next;
    logic [NumEntries-1:0] neg_reg, neg_next;
    logic signed [NW-1:0] ww, xx, yy, zz, xy, xz, yz, xw, yw, zw;

    always_comb
    begin
        prod_next[0] = w_reg * w_reg;
        prod_next[1] = x_reg * x_reg;
        prod_next[2] = y_reg * y_reg;
        prod_next[3] = z_reg * z_reg;
        prod_next[4] = x_reg * y_reg;
        prod_next[5] = x_reg * z_reg;
        prod_next[6] = y_reg * z_reg;
        prod_next[7] = x_reg * w_reg;
        prod_next[8] = y_reg * w_reg;
        prod_next[9] = z_reg * w_reg;
    end

    always_comb
    begin
        ww = NW'($signed(prod_reg[0]));
        xx = NW'($signed(prod_reg[1]));
        yy = NW'($signed(prod_reg[2]));
        zz = NW'($signed(prod_reg[3]));
        xy = NW'($signed(prod_reg[4]));
        xz = NW'($signed(prod_reg[5]));
        yz = NW'($signed(prod_reg[6]));
        xw = NW'($signed(prod_reg[7]));
        yw = NW'($signed(prod_reg[8]));
        zw = NW'($signed(prod_reg[9]));
        num_next[0] = (ww + xx) - (yy + zz);
        num_next[1] = (xy - zw) <<< 1;
        num_next[2] = (xz + yw) <<< 1;
        num_next[3] = (xy + zw) <<< 1;
        num_next[4] = (ww + yy) - (xx + zz);
        num_next[5] = (yz - xw) <<< 1;
        num_next[6] = (xz - yw) <<< 1;
        num_next[7] = (yz + xw) <<< 1;
        num_next[8] = (ww + zz) - (xx + yy);
        n1_next = (ww + xx) + (yy + zz);
    end

    always_comb
    begin
        for (int e = 0; e < NumEntries; e++)
        begin
            neg_next[e] = num_reg[e][NW-1];
            mag_next[e] = neg_next[e] ? NW'(-num_reg[e]) : NW'(num_reg[e]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            ctl_reg <= '0;
        end
        else
        begin
            if (en[0])
                v0_reg <= in_valid;
            if (en[1])
                v1_reg <= v0_reg;
            if (en[2])
                v2_reg <= v1_reg;
            if (en[3])
            begin
                ctl_reg.valid <= v2_reg;
                ctl_reg.zero <= (n1_reg == '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            w_reg <= w;
            x_reg <= x;
            y_reg <= y;
            z_reg <= z;
        end
        if (en[1])
            prod_reg <= prod_next;
        if (en[2])
        begin
            num_reg <= num_next;
            n1_reg <= n1_next;
        end
        if (en[3])
        begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
            n_reg <= n1_reg;
        end
    end

    assign inner_valid = {v2_reg, v1_reg, v0_reg};
    assign ctl = ctl_reg;
    assign n = n_reg;
    assign mag = mag_reg;
    assign neg = neg_reg;
endmodule

### hdl/qrm_div_step.sv
// One restoring division step for all nine entries
module qrm_div_step #(
    parameter int NW = 34,
    parameter int TW = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  qrm_pkg::qrm_ctl_t ctl_in,
    input  logic [NW-1:0] n_in,
    input  logic [qrm_pkg::NumEntries-1:0][NW-1:0] r_in,
    input  logic [qrm_pkg::NumEntries-1:0][TW-1:0] t_in,
    input  logic [qrm_pkg::NumEntries-1:0] neg_in,
    output qrm_pkg::qrm_ctl_t ctl_out,
    output logic [NW-1:0] n_out,
    output logic [qrm_pkg::NumEntries-1:0][NW-1:0] r_out,
    output logic [qrm_pkg::NumEntries-1:0][TW-1:0] t_out,
    output logic [qrm_pkg::NumEntries-1:0] neg_out
);
    import qrm_pkg::*;

    qrm_ctl_t ctl_reg;
    logic [NW-1:0] n_reg;
    logic [NumEntries-1:0][NW-1:0] r_reg, r_next;
    logic [NumEntries-1:0][TW-1:0] t_reg, t_next;
    logic [NumEntries-1:0] neg_reg;
    logic [NW-1:0] diff;
    logic hit;

    always_comb
    begin
        for (int e = 0; e < NumEntries; e++)
        begin
            hit = (r_in[e] >= n_in);
            diff = hit ? (r_in[e] - n_in) : r_in[e];
            r_next[e] = diff << 1;
            t_next[e] = {t_in[e][TW-2:0], hit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg <= n_in;
            r_reg <= r_next;
            t_reg <= t_next;
            neg_reg <= neg_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign n_out = n_reg;
    assign r_out = r_reg;
    assign t_out = t_reg;
    assign neg_out = neg_reg;
endmodule

### hdl/quaternion_to_rotation_matrix.sv
// Top level: quaternion to 3x3 rotation matrix, fully pipelined
//
//  channel  dir  payload                                   handshake
//  q_in     in   q_scalar q_i q_j q_k (COMPONENT_BITS)     valid/ready
//  m_out    out  m00..m22 (FRACTION_BITS+2), zero_norm     valid/ready
//
//  One item enters every cycle unless a stall at m_out holds the pipeline.
//  The depth is set by the restoring divider, one quotient bit per stage.
//  Reset clears every stage valid bit; data registers are not reset.
//  A stage advances when it is empty or the next stage advances, so a
//  stall at m_out fills bubbles first and loses or repeats no item.
module quaternion_to_rotation_matrix #(
    parameter int COMPONENT_BITS = 16,
    parameter int FRACTION_BITS  = 14
) (
    input  logic clk,
    input  logic rst_n,
    qrm_in_if.sink    q_in,
    qrm_out_if.source m_out
);
    import qrm_pkg::*;
    `include "assert_macros.svh"

    localparam int C  = COMPONENT_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int OW = F + 2;
    localparam int NW = 2 * C + 2;
    localparam int TW = F + 2;
    localparam int NS = TW + 5;
    localparam logic signed [OW-1:0] One = OW'(1) << F;

    logic [NS-1:0] en;
    logic [NS-1:0] stage_valid;
    logic [2:0] inner_valid;

    qrm_ctl_t ctl_s [0:TW];
    logic [NW-1:0] n_s [0:TW];
    logic [NumEntries-1:0][NW-1:0] r_s [0:TW];
    logic [NumEntries-1:0][TW-1:0] t_s [0:TW];
    logic [NumEntries-1:0] neg_s [0:TW];

    logic out_valid_reg;
    logic zero_reg;
    logic [NumEntries-1:0][OW-1:0] m_reg, m_next;
    logic [TW-1:0] rounded;
    logic [OW-1:0] mag;

    qrm_front #(.C(C), .NW(NW)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en[3:0]),
        .in_valid    (q_in.valid),
        .w           (q_in.q_scalar),
        .x           (q_in.q_i),
        .y           (q_in.q_j),
        .z           (q_in.q_k),
        .inner_valid (inner_valid),
        .ctl         (ctl_s[0]),
        .n           (n_s[0]),
        .mag         (r_s[0]),
        .neg         (neg_s[0])
    );

    assign t_s[0] = '0;

    for (genvar s = 0; s < TW; s++)
    begin : g_div
        qrm_div_step #(.NW(NW), .TW(TW)) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en[s+4]),
            .ctl_in  (ctl_s[s]),
            .n_in    (n_s[s]),
            .r_in    (r_s[s]),
            .t_in    (t_s[s]),
            .neg_in  (neg_s[s]),
            .ctl_out (ctl_s[s+1]),
            .n_out   (n_s[s+1]),
            .r_out   (r_s[s+1]),
            .t_out   (t_s[s+1]),
            .neg_out (neg_s[s+1])
        );
        assign stage_valid[s+4] = ctl_s[s+1].valid;
    end

    assign stage_valid[2:0] = inner_valid;
    assign stage_valid[3] = ctl_s[0].valid;
    assign stage_valid[NS-1] = out_valid_reg;

    always_comb
    begin
        en[NS-1] = !stage_valid[NS-1] || m_out.ready;
        for (int i = NS - 2; i >= 0; i--)
            en[i] = !stage_valid[i] || en[i+1];
    end

    assign q_in.ready = en[0];

    always_comb
    begin
        for (int e = 0; e < NumEntries; e++)
        begin
            rounded = (t_s[TW][e] + TW'(1)) >> 1;
            mag = OW'(rounded[F:0]);
            if (ctl_s[TW].zero)
                m_next[e] = (e % 4 == 0) ? One : '0;
            else
                m_next[e] = neg_s[TW][e] ? -mag : mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en[NS-1])
            out_valid_reg <= ctl_s[TW].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            m_reg <= m_next;
            zero_reg <= ctl_s[TW].zero;
        end
    end

    assign m_out.valid = out_valid_reg;
    assign m_out.zero_norm = zero_reg;
    assign m_out.m00 = m_reg[0];
    assign m_out.m01 = m_reg[1];
    assign m_out.m02 = m_reg[2];
    assign m_out.m10 = m_reg[3];
    assign m_out.m11 = m_reg[4];
    assign m_out.m12 = m_reg[5];
    assign m_out.m20 = m_reg[6];
    assign m_out.m21 = m_reg[7];
    assign m_out.m22 = m_reg[8];

    `ASSERT_ALWAYS(a_zero_identity, clk, rst_n, !(m_out.valid && m_out.zero_norm) || (m_out.m00 == One && m_out.m01 == '0 && m_out.m22 == One))
    `ASSERT_ALWAYS(a_diag_bound, clk, rst_n, !m_out.valid || ($signed(m_out.m11) <= One && $signed(m_out.m11) >= -One))
    `ASSERT_NEXT(a_accept_fills, clk, rst_n, q_in.valid && q_in.ready, inner_valid[0])
endmodule

### bench/testbench.sv
// Testbench for the quaternion to rotation matrix block: directed table, random stream, checks
module testbench;
    import qrm_pkg::*;

    localparam int CB = 16;
    localparam int FB = 14;
    localparam int OB = FB + 2;
    localparam int LATENCY = FB + 7;
    localparam int NUM_RANDOM = 950;

    typedef struct {
        logic signed [OB-1:0] m [NumEntries];
        logic zero;
    } matrix_t;

    typedef struct {
        logic signed [CB-1:0] w, x, y, z;
        logic has_fixed;
        matrix_t fixed;
    } quat_row_t;

    logic clk;
    logic rst_n;
    qrm_in_if #(.W(CB)) q_in ();
    qrm_out_if #(.W(OB)) m_out ();

    quaternion_to_rotation_matrix #(.COMPONENT_BITS(CB), .FRACTION_BITS(FB)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .q_in(q_in),
        .m_out(m_out)
    );

    matrix_t pending_matrices [$];
    quat_row_t quat_table [$];
    int errors;
    int matrices_seen;
    int zero_seen;
    int quats_sent;
    bit stim_done;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic signed [OB-1:0] round_entry(longint num, longint n);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = ((mag <<< (FB + 1)) + n) / (2 * n);
        if (num < 0)
            q = -q;
        return q[OB-1:0];
    endfunction

    function automatic matrix_t rotation_of(logic signed [CB-1:0] qw, logic signed [CB-1:0] qx,
                                            logic signed [CB-1:0] qy, logic signed [CB-1:0] qz);
        matrix_t r;
        longint w, x, y, z, n;
        w = qw;
        x = qx;
        y = qy;
        z = qz;
        n = w * w + x * x + y * y + z * z;
        r.zero = (n == 0);
        if (n == 0)
        begin
            for (int i = 0; i < NumEntries; i++)
                r.m[i] = (i % 4 == 0) ? OB'(1 << FB) : '0;
            return r;
        end
        r.m[0] = round_entry(w * w + x * x - y * y - z * z, n);
        r.m[1] = round_entry(2 * (x * y - z * w), n);
        r.m[2] = round_entry(2 * (x * z + y * w), n);
        r.m[3] = round_entry(2 * (x * y + z * w), n);
        r.m[4] = round_entry(w * w - x * x + y * y - z * z, n);
        r.m[5] = round_entry(2 * (y * z - x * w), n);
        r.m[6] = round_entry(2 * (x * z - y * w), n);
        r.m[7] = round_entry(2 * (y * z + x * w), n);
        r.m[8] = round_entry(w * w - x * x - y * y + z * z, n);
        return r;
    endfunction

    function automatic matrix_t diag_matrix(int a, int b, int c, logic zero);
        matrix_t r;
        for (int i = 0; i < NumEntries; i++)
            r.m[i] = '0;
        r.m[0] = OB'(a);
        r.m[4] = OB'(b);
        r.m[8] = OB'(c);
        r.zero = zero;
        return r;
    endfunction

    task automatic add_row(int w, int x, int y, int z, logic has_fixed, matrix_t fixed);
        quat_row_t row;
        row.w = CB'(w);
        row.x = CB'(x);
        row.y = CB'(y);
        row.z = CB'(z);
        row.has_fixed = has_fixed;
        row.fixed = fixed;
        quat_table.push_back(row);
    endtask

    function automatic logic signed [CB-1:0] rand_component(int mode);
        case (mode)
            0: return CB'($urandom);
            1: return CB'($urandom_range(0, 15)) - CB'(8);
            2: return ($urandom_range(0, 1) != 0) ? CB'(-32768) : CB'(32767);
            default: return ($urandom_range(0, 3) == 0) ? CB'(0) : CB'($urandom);
        endcase
    endfunction

    task automatic send_quat(quat_row_t row);
        matrix_t want;
        want = row.has_fixed ? row.fixed : rotation_of(row.w, row.x, row.y, row.z);
        q_in.valid <= 1'b1;
        q_in.q_scalar <= row.w;
        q_in.q_i <= row.x;
        q_in.q_j <= row.y;
        q_in.q_k <= row.z;
        @(posedge clk);
        while (!q_in.ready)
            @(posedge clk);
        pending_matrices.push_back(want);
        quats_sent++;
    endtask

    initial
    begin
        int burst;
        int gap;
        quat_row_t row;
        matrix_t none;
        errors = 0;
        matrices_seen = 0;
        zero_seen = 0;
        quats_sent = 0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        q_in.valid = 1'b0;
        q_in.q_scalar = '0;
        q_in.q_i = '0;
        q_in.q_j = '0;
        q_in.q_k = '0;
        none = diag_matrix(0, 0, 0, 1'b0);
        add_row(0, 0, 0, 0, 1'b1, diag_matrix(16384, 16384, 16384, 1'b1));
        add_row(1, 0, 0, 0, 1'b1, diag_matrix(16384, 16384, 16384, 1'b0));
        add_row(-32768, 0, 0, 0, 1'b1, diag_matrix(16384, 16384, 16384, 1'b0));
        add_row(32767, 0, 0, 0, 1'b1, diag_matrix(16384, 16384, 16384, 1'b0));
        add_row(0, 1, 0, 0, 1'b1, diag_matrix(16384, -16384, -16384, 1'b0));
        add_row(0, 0, -32768, 0, 1'b1, diag_matrix(-16384, 16384, -16384, 1'b0));
        add_row(0, 0, 0, 32767, 1'b1, diag_matrix(-16384, -16384, 16384, 1'b0));
        add_row(-32768, -32768, -32768, -32768, 1'b0, none);
        add_row(32767, 32767, 32767, 32767, 1'b0, none);
        add_row(32767, -32768, 32767, -32768, 1'b0, none);
        add_row(1, 1, 0, 0, 1'b0, none);
        add_row(-1, -1, 0, 0, 1'b0, none);
        add_row(1, 0, 1, 0, 1'b0, none);
        add_row(1, 0, 0, 1, 1'b0, none);
        add_row(1, 1, 1, 1, 1'b0, none);
        add_row(1, 2, 3, 4, 1'b0, none);
        add_row(-1, -2, -3, -4, 1'b0, none);
        add_row(3, 0, 0, 0, 1'b0, none);
        add_row(1, 1, 1, 0, 1'b0, none);
        add_row(-21846, 21845, -1, 1, 1'b0, none);
        add_row(0, 32767, -32768, 12345, 1'b0, none);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (quat_table[i])
            send_quat(quat_table[i]);
        for (int n = 0; n < NUM_RANDOM;)
        begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < NUM_RANDOM; b++, n++)
            begin
                int mode;
                mode = $urandom_range(0, 3);
                row.w = rand_component(mode);
                row.x = rand_component(mode);
                row.y = rand_component(mode);
                row.z = rand_component(mode);
                row.has_fixed = 1'b0;
                send_quat(row);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                q_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        q_in.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        int phase;
        m_out.ready = 1'b0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            phase = (phase + 1) % 300;
            if (phase < 60)
                m_out.ready <= 1'b1;
            else if (phase < 200)
                m_out.ready <= ($urandom_range(0, 2) != 0);
            else
                m_out.ready <= ($urandom_range(0, 4) == 0);
        end
    end

    always @(posedge clk)
    begin
        matrix_t got;
        matrix_t want;
        if (rst_n && m_out.valid && m_out.ready)
        begin
            got.m[0] = m_out.m00;
            got.m[1] = m_out.m01;
            got.m[2] = m_out.m02;
            got.m[3] = m_out.m10;
            got.m[4] = m_out.m11;
            got.m[5] = m_out.m12;
            got.m[6] = m_out.m20;
            got.m[7] = m_out.m21;
            got.m[8] = m_out.m22;
            got.zero = m_out.zero_norm;
            matrices_seen++;
            if (got.zero)
                zero_seen++;
            if (pending_matrices.size() == 0)
            begin
                $display("%0t: unexpected matrix, expected none, actual m00=%0d zero=%0b",
                         $time, got.m[0], got.zero);
                errors++;
            end
            else
            begin
                want = pending_matrices.pop_front();
                for (int i = 0; i < NumEntries; i++)
                    if (got.m[i] !== want.m[i])
                    begin
                        $display("%0t: entry m%0d%0d expected %0d actual %0d",
                                 $time, i / 3, i % 3, want.m[i], got.m[i]);
                        errors++;
                    end
                if (got.zero !== want.zero)
                begin
                    $display("%0t: zero_norm expected %0b actual %0b",
                             $time, want.zero, got.zero);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (pending_matrices.size() != 0)
            @(posedge clk);
        repeat (LATENCY * 4) @(posedge clk);
        if (pending_matrices.size() != 0)
            errors++;
        $display("Sent %0d quaternions, checked %0d matrices (%0d zero-norm).",
                 quats_sent, matrices_seen, zero_seen);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timed out with %0d matrices outstanding.", pending_matrices.size());
        $display("testbench: FAIL");
        $finish;
    end
endmodule
